[rtl/held_key_table_min_report_unit_assert.svh]
// assertion macros for the held key table
`ifndef HELD_KEY_TABLE_MIN_REPORT_UNIT_ASSERT_SVH
`define HELD_KEY_TABLE_MIN_REPORT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define HKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the following cycle
`define HKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/hktmr_pkg.sv]
// shared types and constants of the held key table
package hktmr_pkg;

    localparam int RESULT_CAP = 8;
    localparam int RIW        = 3;
    localparam int REP_W      = 4;

    localparam logic [7:0] SEEN_CAP     = 8'd255;
    localparam logic [7:0] HOLD_MIN_RST = 8'd2;

    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_SNAP  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] seen;
        logic       pend;
    } t_entry;

    // capture of a reported key during the snapshot pass
    typedef struct packed {
        logic           we;
        logic [RIW-1:0] idx;
        logic [7:0]     row;
        logic [7:0]     col;
    } t_cap;

    // load of one result item into the output register
    typedef struct packed {
        logic             load;
        logic [RIW-1:0]   idx;
        logic             ent;
        logic             last;
        logic [REP_W-1:0] rep;
        logic [REP_W-1:0] held;
    } t_emit;

endpackage

[rtl/held_key_table_min_report_unit.sv]
// held key table: key events, snapshots with deferred release, release-all
// key event: accept, a memory read and a compare per entry searched, a read and a move
// per entry shifted down behind a removed key, an add step on a miss, then a result load
// snapshot: accept, a read and an update per held entry, then one load per result item
// results show in the cycle after loading and wait while the output register is full
// reset (synchronous, active low) empties the table and sets the release threshold to 2
`include "held_key_table_min_report_unit_assert.svh"

module held_key_table_min_report_unit
    import hktmr_pkg::*;
#(
    parameter int MAX_KEYS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_key_row,
    input  logic [7:0]       i_key_col,
    input  logic             i_pressed,
    input  logic [7:0]       i_snapshot_limit,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_row,
    output logic [7:0]       o_out_col,
    output logic             o_entry_valid,
    output logic             o_last,
    output logic [REP_W-1:0] o_reported_count,
    output logic [REP_W-1:0] o_held_count
);

    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_KEYS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_EV   = 7'b0000100,
        S_SHRD = 7'b0001000,
        S_SHEV = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_wp, n_wp;
    logic [1:0]       r_req, n_req;
    logic [7:0]       r_row, n_row;
    logic [7:0]       r_col, n_col;
    logic             r_down, n_down;
    logic [REP_W-1:0] r_n, n_n;
    logic [RIW-1:0]   r_emit, n_emit;
    logic [7:0]       r_hold_min;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic [IW-1:0]    mem_raddr;
    t_entry           mem_rdata;
    t_cap             cap;
    t_emit            emit;
    logic             ob_space;

    logic [CW+7:0]    acc_cnt_x;
    logic [CW+7:0]    acc_lim_x;
    logic [CW+7:0]    acc_min;
    logic [REP_W-1:0] acc_n;
    logic [CW+2:0]    idx_x;
    logic [CW+2:0]    n_x;
    logic [CW+3:0]    held_x;
    logic [REP_W-1:0] emit_x;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    wp_next;
    logic             more;
    logic             match;
    logic [7:0]       seen_inc;
    logic             drop;
    logic             last_c;

    hktmr_mem #(
        .DEPTH (MAX_KEYS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hktmr_obuf u_obuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cap            (cap),
        .i_emit           (emit),
        .o_space          (ob_space),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_entry_valid    (o_entry_valid),
        .o_last           (o_last),
        .o_reported_count (o_reported_count),
        .o_held_count     (o_held_count)
    );

    // number of keys a snapshot reports, from the count before the step
    assign acc_cnt_x = {8'd0, r_cnt};
    assign acc_lim_x = {{CW{1'b0}}, i_snapshot_limit};
    assign acc_min   = (acc_cnt_x < acc_lim_x) ? acc_cnt_x : acc_lim_x;
    assign acc_n     = (acc_min > (CW+8)'(RESULT_CAP)) ? REP_W'(RESULT_CAP)
                                                        : acc_min[REP_W-1:0];

    assign idx_x    = {3'b000, r_idx};
    assign n_x      = (CW+3)'(r_n);
    assign held_x   = {4'b0000, r_cnt};
    assign emit_x   = {1'b0, r_emit};
    assign idx_inc  = r_idx + ONE;
    assign idx_dec  = r_idx - ONE;
    assign more     = idx_inc < r_cnt;
    assign match    = (mem_rdata.row == r_row) && (mem_rdata.col == r_col);
    assign seen_inc = (mem_rdata.seen == SEEN_CAP) ? SEEN_CAP : mem_rdata.seen + 8'd1;
    assign drop     = mem_rdata.pend && (seen_inc >= r_hold_min);
    assign wp_next  = drop ? r_wp : r_wp + ONE;
    assign last_c   = (r_n == '0) || ((emit_x + 4'd1) == r_n);

    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_wp      = r_wp;
        n_req     = r_req;
        n_row     = r_row;
        n_col     = r_col;
        n_down    = r_down;
        n_n       = r_n;
        n_emit    = r_emit;
        mem_we    = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[IW-1:0];
        cap       = '0;
        emit      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req  = i_req_type;
                    n_row  = i_key_row;
                    n_col  = i_key_col;
                    n_down = i_pressed;
                    n_idx  = '0;
                    n_wp   = '0;
                    n_emit = '0;
                    n_n    = '0;
                    case (i_req_type)
                        REQ_KEY: begin
                            n_state = (r_cnt == '0) ? S_ADD : S_RD;
                        end
                        REQ_SNAP: begin
                            n_n     = acc_n;
                            n_state = (r_cnt == '0) ? S_EMIT : S_RD;
                        end
                        REQ_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_req == REQ_SNAP) begin
                    cap.we  = idx_x < n_x;
                    cap.idx = idx_x[RIW-1:0];
                    cap.row = mem_rdata.row;
                    cap.col = mem_rdata.col;
                    // compact in place: the write pointer never passes the read index
                    if (!drop) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wp[IW-1:0];
                        mem_wdata = '{row: mem_rdata.row, col: mem_rdata.col,
                                      seen: seen_inc, pend: mem_rdata.pend};
                    end
                    n_wp = wp_next;
                    if (more) begin
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end else begin
                        n_cnt   = wp_next;
                        n_state = S_EMIT;
                    end
                end else if (match) begin
                    if (r_down) begin
                        mem_we         = 1'b1;
                        mem_wdata.pend = 1'b0;
                        n_state        = S_EMIT;
                    end else if (mem_rdata.seen >= r_hold_min) begin
                        if (more) begin
                            n_idx   = idx_inc;
                            n_state = S_SHRD;
                        end else begin
                            n_cnt   = r_cnt - ONE;
                            n_state = S_EMIT;
                        end
                    end else begin
                        mem_we         = 1'b1;
                        mem_wdata.pend = 1'b1;
                        n_state        = S_EMIT;
                    end
                end else if (more) begin
                    n_idx   = idx_inc;
                    n_state = S_RD;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_SHRD: begin
                n_state = S_SHEV;
            end
            S_SHEV: begin
                // move the entry just read one place down
                mem_we    = 1'b1;
                mem_waddr = idx_dec[IW-1:0];
                if (more) begin
                    n_idx   = idx_inc;
                    n_state = S_SHRD;
                end else begin
                    n_cnt   = r_cnt - ONE;
                    n_state = S_EMIT;
                end
            end
            S_ADD: begin
                if (r_down && (r_cnt < CNT_MAX)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[IW-1:0];
                    mem_wdata = '{row: r_row, col: r_col, seen: 8'd0, pend: 1'b0};
                    n_cnt     = r_cnt + ONE;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (ob_space) begin
                    emit.load = 1'b1;
                    emit.idx  = r_emit;
                    emit.ent  = (r_n != '0);
                    emit.last = last_c;
                    emit.rep  = r_n;
                    emit.held = held_x[REP_W-1:0];
                    if (last_c) begin
                        n_state = S_IDLE;
                    end else begin
                        n_emit = r_emit + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_hold_min <= HOLD_MIN_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_hold_min <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_wp   <= n_wp;
        r_req  <= n_req;
        r_row  <= n_row;
        r_col  <= n_col;
        r_down <= n_down;
        r_n    <= n_n;
        r_emit <= n_emit;
    end

    `HKT_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_MAX, "entry count above table size")
    `HKT_ASSERT(a_wp_behind, i_clk, i_rst_n,
        !((r_state == S_EV) && (r_req == REQ_SNAP)) || (r_wp <= r_idx),
        "compaction write pointer passed read index")
    `HKT_ASSERT(a_emit_range, i_clk, i_rst_n,
        !((r_state == S_EMIT) && (r_n != '0)) || (emit_x < r_n),
        "result index beyond reported count")
    `HKT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready,
        r_state != S_IDLE, "accepted item left the sequencer idle")

endmodule

[rtl/hktmr_mem.sv]
// entry memory: one write port, one registered read port
module hktmr_mem
    import hktmr_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/hktmr_obuf.sv]
// snapshot capture buffer and output register
module hktmr_obuf
    import hktmr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cap             i_cap,
    input  t_emit            i_emit,
    output logic             o_space,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_out_row,
    output logic [7:0]       o_out_col,
    output logic             o_entry_valid,
    output logic             o_last,
    output logic [REP_W-1:0] o_reported_count,
    output logic [REP_W-1:0] o_held_count
);

    logic [7:0]       r_buf_row [RESULT_CAP];
    logic [7:0]       r_buf_col [RESULT_CAP];
    logic             r_valid;
    logic [7:0]       r_row;
    logic [7:0]       r_col;
    logic             r_ent;
    logic             r_last;
    logic [REP_W-1:0] r_rep;
    logic [REP_W-1:0] r_held;

    always_ff @(posedge i_clk) begin
        if (i_cap.we) begin
            r_buf_row[i_cap.idx] <= i_cap.row;
            r_buf_col[i_cap.idx] <= i_cap.col;
        end
        if (i_emit.load) begin
            r_row  <= i_emit.ent ? r_buf_row[i_emit.idx] : 8'd0;
            r_col  <= i_emit.ent ? r_buf_col[i_emit.idx] : 8'd0;
            r_ent  <= i_emit.ent;
            r_last <= i_emit.last;
            r_rep  <= i_emit.rep;
            r_held <= i_emit.held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_space          = !r_valid || i_ready;
    assign o_valid          = r_valid;
    assign o_out_row        = r_row;
    assign o_out_col        = r_col;
    assign o_entry_valid    = r_ent;
    assign o_last           = r_last;
    assign o_reported_count = r_rep;
    assign o_held_count     = r_held;

endmodule
